FILE: hw/rtl/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CNT_OUT_W = 11;
	localparam int BC_W = 9;
	localparam int STAT_W = 3;

	localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STAT_W-1:0] ST_HIT = 3'd2;
	localparam logic [STAT_W-1:0] ST_MISS = 3'd3;
	localparam logic [STAT_W-1:0] ST_POOL_FULL = 3'd4;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [VAL_W-1:0] ZERO_VALUE = '0;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [BC_W-1:0] BC_RESET = 9'd256;

	localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_HRD,
		S_HEAD,
		S_CHK,
		S_CMP,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/chm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module chm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [chm_pkg::KEY_W-1:0]    key,
	input  wire logic [chm_pkg::BC_W-1:0]     divisor,
	output logic                              done,
	output logic [chm_pkg::BC_W-1:0]          rem
);

	localparam int CW = $clog2(chm_pkg::KEY_W);

	logic                       run_q;
	logic [CW-1:0]              cnt_q;
	logic [chm_pkg::KEY_W-1:0]  key_q;
	logic [chm_pkg::BC_W-1:0]   rem_q;
	logic [chm_pkg::BC_W-1:0]   div_q;
	logic [chm_pkg::BC_W:0]     trial;
	logic [chm_pkg::BC_W:0]     nrem;

	always_comb begin
		trial = {rem_q, key_q[chm_pkg::KEY_W-1]};
		if (trial >= {1'b0, div_q}) begin
			nrem = trial - {1'b0, div_q};
		end else begin
			nrem = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(chm_pkg::KEY_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			key_q <= key;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			key_q <= key_q << 1;
			rem_q <= nrem[chm_pkg::BC_W-1:0];
		end
	end

	assign done = run_q && (cnt_q == CW'(chm_pkg::KEY_W - 1));
	assign rem = rem_q;

endmodule
`default_nettype wire

FILE: hw/rtl/chm_heads.sv
`timescale 1ns / 1ps
`default_nettype none
module chm_heads #(
	parameter int BUCKETS = 256,
	parameter int BW = 8,
	parameter int IW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [BW-1:0] rd_addr,
	output logic [IW-1:0]      rd_head,
	output logic               rd_valid,
	input  wire logic          wr_en,
	input  wire logic [BW-1:0] wr_addr,
	input  wire logic [IW-1:0] wr_head
);

	logic [IW-1:0]      mem [BUCKETS];
	logic [BUCKETS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_head;
		end
		if (rd_en) begin
			rd_head <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/chm_nodes.sv
`timescale 1ns / 1ps
`default_nettype none
module chm_nodes #(
	parameter int NODES = 1024,
	parameter int IW = 10
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [IW-1:0]               rd_addr,
	output logic [chm_pkg::KEY_W-1:0]        rd_key,
	output logic [chm_pkg::VAL_W-1:0]        rd_value,
	output logic                             rd_link_valid,
	output logic [IW-1:0]                    rd_link,
	input  wire logic                        wr_en,
	input  wire logic [IW-1:0]               wr_addr,
	input  wire logic [chm_pkg::KEY_W-1:0]   wr_key,
	input  wire logic [chm_pkg::VAL_W-1:0]   wr_value,
	input  wire logic                        wr_link_valid,
	input  wire logic [IW-1:0]               wr_link
);

	localparam int DW = chm_pkg::KEY_W + chm_pkg::VAL_W + 1 + IW;

	logic [DW-1:0] mem [NODES];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_key, wr_value, wr_link_valid, wr_link};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign {rd_key, rd_value, rd_link_valid, rd_link} = rd_q;

endmodule
`default_nettype wire

FILE: hw/rtl/chained_hash_map.sv
`timescale 1ns / 1ps
`default_nettype none
// Key/value map with separate chaining. A transaction is taken when start is high and busy is
// low; it reduces the key modulo the bucket count in a bit-serial remainder unit, fetches the
// bucket head, visits the chain nodes one by one in the node memory, sees the end of the chain
// when the key is absent and then writes back. The result appears with done high for exactly
// one cycle, the first cycle with busy low, and cannot be stalled; the receiver must take it
// then. The user must write bucket_count over the APB port only while the block is idle; the
// block itself does not enforce it.
module chained_hash_map #(
	parameter int BUCKETS = 256,
	parameter int NODES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               func,
	input  wire logic [chm_pkg::KEY_W-1:0]          key,
	input  wire logic signed [chm_pkg::VAL_W-1:0]   value,
	output logic                                    done,
	output logic [chm_pkg::STAT_W-1:0]              status,
	output logic signed [chm_pkg::VAL_W-1:0]        read_value,
	output logic [chm_pkg::CNT_OUT_W-1:0]           entry_count
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = $clog2(NODES + 1);

	chm_pkg::state_t state_q, state_d;

	logic [chm_pkg::BC_W-1:0]  bc_q;
	logic [chm_pkg::BC_W-1:0]  divisor;
	logic                      cfg_wr;

	logic                      func_q;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] value_q;
	logic [BW-1:0]             bucket_q;
	logic [IW-1:0]             head_q;
	logic                      head_vld_q;
	logic [IW-1:0]             cur_q;
	logic                      cur_vld_q;
	logic [CW-1:0]             steps_q;
	logic                      found_q;
	logic [chm_pkg::VAL_W-1:0] found_val_q;
	logic                      found_lv_q;
	logic [IW-1:0]             found_link_q;
	logic [CW-1:0]             count_q;

	logic                      accept;
	logic                      div_done;
	logic [chm_pkg::BC_W-1:0]  div_rem;
	logic                      walk_ok;
	logic                      pool_full;

	logic                      hd_rd;
	logic [IW-1:0]             hd_head;
	logic                      hd_valid;
	logic                      hd_wr;

	logic                      nd_rd;
	logic [chm_pkg::KEY_W-1:0] nd_key;
	logic [chm_pkg::VAL_W-1:0] nd_value;
	logic                      nd_lv;
	logic [IW-1:0]             nd_link;
	logic                      nd_wr;
	logic [IW-1:0]             nd_wr_addr;
	logic                      nd_wr_lv;
	logic [IW-1:0]             nd_wr_link;
	logic                      ins;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == chm_pkg::ADDR_BUCKET_COUNT);
	assign prdata = (paddr == chm_pkg::ADDR_BUCKET_COUNT) ? {23'd0, bc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= chm_pkg::BC_RESET;
		end else if (cfg_wr) begin
			bc_q <= pwdata[chm_pkg::BC_W-1:0];
		end
	end

	always_comb begin
		if (bc_q == '0) begin
			divisor = chm_pkg::BC_W'(1);
		end else if (32'(bc_q) > BUCKETS) begin
			divisor = chm_pkg::BC_W'(BUCKETS);
		end else begin
			divisor = bc_q;
		end
	end

	assign accept = start && !busy;
	assign busy = (state_q != chm_pkg::S_IDLE);

	chm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.key     (key),
		.divisor (divisor),
		.done    (div_done),
		.rem     (div_rem)
	);

	assign walk_ok = cur_vld_q && (CW'(cur_q) < CW'(NODES)) && (steps_q < CW'(NODES));
	assign pool_full = (count_q >= CW'(NODES));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chm_pkg::S_IDLE: begin
				if (accept) state_d = chm_pkg::S_DIV;
			end
			chm_pkg::S_DIV: begin
				if (div_done) state_d = chm_pkg::S_HRD;
			end
			chm_pkg::S_HRD: state_d = chm_pkg::S_HEAD;
			chm_pkg::S_HEAD: state_d = chm_pkg::S_CHK;
			chm_pkg::S_CHK: begin
				state_d = walk_ok ? chm_pkg::S_CMP : chm_pkg::S_DONE;
			end
			chm_pkg::S_CMP: begin
				state_d = (nd_key == key_q) ? chm_pkg::S_DONE : chm_pkg::S_CHK;
			end
			chm_pkg::S_DONE: state_d = chm_pkg::S_IDLE;
			default: state_d = chm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		hd_rd = (state_q == chm_pkg::S_HRD);
		nd_rd = (state_q == chm_pkg::S_CHK) && walk_ok;
		ins = (state_q == chm_pkg::S_DONE) && (func_q == chm_pkg::FUNC_INSERT)
			&& !found_q && !pool_full;
		hd_wr = ins;
		nd_wr = ins || ((state_q == chm_pkg::S_DONE) && (func_q == chm_pkg::FUNC_INSERT)
			&& found_q);
		nd_wr_addr = found_q ? cur_q : count_q[IW-1:0];
		nd_wr_lv = found_q ? found_lv_q : head_vld_q;
		nd_wr_link = found_q ? found_link_q : head_q;
	end

	chm_heads #(.BUCKETS(BUCKETS), .BW(BW), .IW(IW)) u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (hd_rd),
		.rd_addr  (BW'(div_rem)),
		.rd_head  (hd_head),
		.rd_valid (hd_valid),
		.wr_en    (hd_wr),
		.wr_addr  (bucket_q),
		.wr_head  (count_q[IW-1:0])
	);

	chm_nodes #(.NODES(NODES), .IW(IW)) u_nodes (
		.clk           (clk),
		.rd_en         (nd_rd),
		.rd_addr       (cur_q),
		.rd_key        (nd_key),
		.rd_value      (nd_value),
		.rd_link_valid (nd_lv),
		.rd_link       (nd_link),
		.wr_en         (nd_wr),
		.wr_addr       (nd_wr_addr),
		.wr_key        (key_q),
		.wr_value      (value_q),
		.wr_link_valid (nd_wr_lv),
		.wr_link       (nd_wr_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::S_IDLE;
			count_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == chm_pkg::S_DONE);
			if (ins) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q <= key;
			value_q <= value;
			found_q <= 1'b0;
		end
		if (hd_rd) begin
			bucket_q <= BW'(div_rem);
		end
		if (state_q == chm_pkg::S_HEAD) begin
			head_q <= hd_head;
			head_vld_q <= hd_valid;
			cur_q <= hd_head;
			cur_vld_q <= hd_valid;
			steps_q <= '0;
		end
		if (state_q == chm_pkg::S_CMP) begin
			if (nd_key == key_q) begin
				found_q <= 1'b1;
				found_val_q <= nd_value;
				found_lv_q <= nd_lv;
				found_link_q <= nd_link;
			end else begin
				cur_q <= nd_link;
				cur_vld_q <= nd_lv;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (state_q == chm_pkg::S_DONE) begin
			if (func_q == chm_pkg::FUNC_LOOKUP) begin
				status <= found_q ? chm_pkg::ST_HIT : chm_pkg::ST_MISS;
				read_value <= found_q ? found_val_q : chm_pkg::MISS_VALUE;
			end else begin
				read_value <= chm_pkg::ZERO_VALUE;
				if (found_q) begin
					status <= chm_pkg::ST_UPDATED;
				end else if (pool_full) begin
					status <= chm_pkg::ST_POOL_FULL;
				end else begin
					status <= chm_pkg::ST_INSERTED;
				end
			end
			entry_count <= chm_pkg::CNT_OUT_W'(ins ? count_q + 1'b1 : count_q);
		end
	end

endmodule
`default_nettype wire

FILE: tb/hash_map_checker.sv
`timescale 1ns / 1ps
module hash_map_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               pready,
	input  logic                               start,
	input  logic                               busy,
	input  logic                               func,
	input  logic [chm_pkg::KEY_W-1:0]          key,
	input  logic signed [chm_pkg::VAL_W-1:0]   value,
	input  logic                               done,
	input  logic [chm_pkg::STAT_W-1:0]         status,
	input  logic signed [chm_pkg::VAL_W-1:0]   read_value,
	input  logic [chm_pkg::CNT_OUT_W-1:0]      entry_count,
	output int                                 pending,
	output int                                 errors
);

	localparam int N_BUCKETS = 256;
	localparam int N_NODES = 1024;

	typedef struct packed {
		logic [chm_pkg::STAT_W-1:0] status;
		logic [chm_pkg::VAL_W-1:0] read_value;
		logic [chm_pkg::CNT_OUT_W-1:0] entry_count;
	} map_result_t;

	logic [chm_pkg::BC_W-1:0] buckets_cfg;
	logic [10:0] head_node [N_BUCKETS];
	logic head_ok [N_BUCKETS];
	logic [chm_pkg::KEY_W-1:0] slot_key [N_NODES];
	logic [chm_pkg::VAL_W-1:0] slot_value [N_NODES];
	logic [10:0] slot_next [N_NODES];
	logic slot_next_ok [N_NODES];
	int free_slot;
	logic [chm_pkg::CNT_OUT_W-1:0] key_total;
	map_result_t expected_results [$];

	assign pending = expected_results.size();

	task automatic apply_op(input logic f, input logic [chm_pkg::KEY_W-1:0] k,
			input logic [chm_pkg::VAL_W-1:0] v, output map_result_t r);
		int d;
		int b;
		int cur;
		int steps;
		int hit_at;
		logic ok;
		d = (buckets_cfg == '0) ? 1 :
			((int'(buckets_cfg) > N_BUCKETS) ? N_BUCKETS : int'(buckets_cfg));
		b = int'({1'b0, k} % 32'(d));
		ok = head_ok[b];
		cur = int'(head_node[b]);
		steps = 0;
		hit_at = -1;
		while (ok && cur < N_NODES && steps < N_NODES && hit_at < 0) begin
			if (slot_key[cur] == k) begin
				hit_at = cur;
			end else begin
				ok = slot_next_ok[cur];
				cur = int'(slot_next[cur]);
				steps++;
			end
		end
		r.read_value = chm_pkg::ZERO_VALUE;
		if (f == chm_pkg::FUNC_LOOKUP) begin
			if (hit_at >= 0) begin
				r.status = chm_pkg::ST_HIT;
				r.read_value = slot_value[hit_at];
			end else begin
				r.status = chm_pkg::ST_MISS;
				r.read_value = chm_pkg::MISS_VALUE;
			end
		end else if (hit_at >= 0) begin
			slot_value[hit_at] = v;
			r.status = chm_pkg::ST_UPDATED;
		end else if (free_slot >= N_NODES) begin
			r.status = chm_pkg::ST_POOL_FULL;
		end else begin
			slot_key[free_slot] = k;
			slot_value[free_slot] = v;
			slot_next[free_slot] = head_node[b];
			slot_next_ok[free_slot] = head_ok[b];
			head_node[b] = 11'(free_slot);
			head_ok[b] = 1'b1;
			free_slot++;
			key_total++;
			r.status = chm_pkg::ST_INSERTED;
		end
		r.entry_count = key_total;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		buckets_cfg = chm_pkg::BC_RESET;
		free_slot = 0;
		key_total = '0;
		for (int i = 0; i < N_BUCKETS; i++) begin
			head_ok[i] = 1'b0;
			head_node[i] = '0;
		end
	end

	always @(negedge clk) begin
		map_result_t r;
		map_result_t w;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("mismatch at %0t: result with no transaction outstanding", $realtime);
					errors++;
				end else begin
					w = expected_results.pop_front();
					if (status !== w.status)
						report("status", 32'(status), 32'(w.status));
					if (read_value !== w.read_value)
						report("read_value", read_value, w.read_value);
					if (entry_count !== w.entry_count)
						report("entry_count", 32'(entry_count), 32'(w.entry_count));
				end
			end
			if (start && !busy) begin
				apply_op(func, key, value, r);
				expected_results.push_back(r);
			end
			if (psel && penable && pwrite && pready && paddr == chm_pkg::ADDR_BUCKET_COUNT)
				buckets_cfg = pwdata[chm_pkg::BC_W-1:0];
		end
	end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam logic [chm_pkg::KEY_W-1:0] KEY_MAX = '1;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start, busy, func;
	logic [chm_pkg::KEY_W-1:0] key;
	logic signed [chm_pkg::VAL_W-1:0] value;
	logic done;
	logic [chm_pkg::STAT_W-1:0] status;
	logic signed [chm_pkg::VAL_W-1:0] read_value;
	logic [chm_pkg::CNT_OUT_W-1:0] entry_count;
	int pending;
	int errors;

	logic [chm_pkg::KEY_W-1:0] known_keys [$];
	int fresh_inserts;
	bit no_gaps;

	chained_hash_map dut (.*);

	hash_map_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20ms;
		$display("testbench failed");
		$finish;
	end

	task automatic send_op(input logic f, input logic [chm_pkg::KEY_W-1:0] k,
			input logic [chm_pkg::VAL_W-1:0] v);
		int gap;
		bit taken;
		func <= f;
		key <= k;
		value <= v;
		start <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		gap = no_gaps ? 0 : $urandom_range(7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_buckets(input logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= chm_pkg::ADDR_BUCKET_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [chm_pkg::KEY_W-1:0] fresh_key();
		return chm_pkg::KEY_W'($urandom);
	endfunction

	function automatic logic [chm_pkg::KEY_W-1:0] some_known_key();
		if (known_keys.size() == 0)
			return fresh_key();
		return known_keys[$urandom_range(known_keys.size() - 1)];
	endfunction

	task automatic insert_fresh();
		logic [chm_pkg::KEY_W-1:0] k;
		k = fresh_key();
		known_keys.push_back(k);
		fresh_inserts++;
		send_op(chm_pkg::FUNC_INSERT, k, $urandom);
	endtask

	task automatic mixed_op();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			insert_fresh();
		else if (r < 65)
			send_op(chm_pkg::FUNC_LOOKUP, some_known_key(), $urandom);
		else if (r < 85)
			send_op(chm_pkg::FUNC_INSERT, some_known_key(), $urandom);
		else
			send_op(chm_pkg::FUNC_LOOKUP, fresh_key(), $urandom);
	endtask

	initial begin
		int counts [7];
		int tail;
		counts = '{1, 0, 511, 3, 256, 37, 200};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = chm_pkg::FUNC_INSERT;
		key = '0;
		value = '0;
		fresh_inserts = 0;
		no_gaps = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, collisions in one bucket, update, ignored value
		send_op(chm_pkg::FUNC_LOOKUP, '0, 32'h1234_5678);
		send_op(chm_pkg::FUNC_INSERT, '0, 32'h8000_0000);
		send_op(chm_pkg::FUNC_INSERT, KEY_MAX, 32'h7fff_ffff);
		send_op(chm_pkg::FUNC_INSERT, 31'd256, 32'hffff_ffff);
		send_op(chm_pkg::FUNC_INSERT, 31'd512, 32'h0);
		send_op(chm_pkg::FUNC_INSERT, 31'h7fff_ff00, 32'haaaa_aaaa);
		send_op(chm_pkg::FUNC_INSERT, 31'h2aaa_aaaa, 32'h5555_5555);
		send_op(chm_pkg::FUNC_INSERT, 31'h5555_5555, 32'haaaa_aaaa);
		send_op(chm_pkg::FUNC_LOOKUP, '0, '0);
		send_op(chm_pkg::FUNC_LOOKUP, 31'd256, '0);
		send_op(chm_pkg::FUNC_LOOKUP, 31'd512, '1);
		send_op(chm_pkg::FUNC_LOOKUP, KEY_MAX, '0);
		send_op(chm_pkg::FUNC_LOOKUP, 31'd768, '0);
		send_op(chm_pkg::FUNC_INSERT, 31'd256, 32'd12345);
		send_op(chm_pkg::FUNC_LOOKUP, 31'd256, '0);
		send_op(chm_pkg::FUNC_INSERT, KEY_MAX, 32'h8000_0000);
		send_op(chm_pkg::FUNC_LOOKUP, KEY_MAX, '0);
		send_op(chm_pkg::FUNC_LOOKUP, 31'h7fff_ff00, '0);
		send_op(chm_pkg::FUNC_LOOKUP, 31'h2aaa_aaaa, '0);
		known_keys.push_back('0);
		known_keys.push_back(KEY_MAX);
		known_keys.push_back(31'd256);
		drain();

		// bucket count changes with entries stored, degenerate and saturating counts
		foreach (counts[i]) begin
			write_buckets(32'(counts[i]));
			no_gaps = (i % 2 == 1);
			repeat (10) mixed_op();
			drain();
		end

		// fill the pool, then keep hammering it while full
		write_buckets(32'd256);
		no_gaps = 0;
		while (fresh_inserts < 1040) begin
			if ($urandom_range(99) < 96)
				insert_fresh();
			else
				send_op(chm_pkg::FUNC_LOOKUP, some_known_key(), $urandom);
		end
		tail = 0;
		while (tail < 30) begin
			no_gaps = (tail >= 15);
			mixed_op();
			tail++;
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
